@@ sv/ertcc_pkg.sv @@
package ertcc_pkg;

    // messages per input item before the remainder waits for the next item
    localparam int MaxBurst = 16;
    localparam int BurstW   = $clog2(MaxBurst + 1);

    // command queue between front and back
    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    // largest step count carried by one message
    localparam logic [3:0] StepClamp = 4'd15;

    // encoding modes
    localparam logic [1:0] ModeTwos    = 2'd0;
    localparam logic [1:0] ModeOffset  = 2'd1;
    localparam logic [1:0] ModeSignMag = 2'd2;

    // register indexes
    localparam logic [2:0] RegPps         = 3'd0;
    localparam logic [2:0] RegGain        = 3'd1;
    localparam logic [2:0] RegMode        = 3'd2;
    localparam logic [2:0] RegBaseChannel = 3'd3;
    localparam logic [2:0] RegBaseCtl     = 3'd4;
    localparam logic [2:0] RegBankChOff   = 3'd5;
    localparam logic [2:0] RegBankAddrOff = 3'd6;
    localparam logic [2:0] RegBankWidth   = 3'd7;

    typedef struct packed {
        logic [7:0] pps;
        logic [7:0] gain;
        logic [1:0] mode;
        logic [7:0] base_channel;
        logic [7:0] base_controller;
        logic [7:0] bank_channel_offset;
        logic [7:0] bank_address_offset;
        logic [7:0] bank_width;
    } t_cfg;

    // one message to emit: signed clamped step count and end-of-burst mark
    typedef struct packed {
        logic       neg;
        logic [3:0] mag;
        logic       last;
    } t_cmd;

endpackage

@@ sv/ertcc_front.sv @@
module ertcc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ertcc_pkg::t_cfg     i_cfg,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [31:0]  i_encoder_position,
    output ertcc_pkg::t_cmd     o_cmd,
    output logic                o_push,
    input  logic                i_full
);
    import ertcc_pkg::*;

    localparam logic [1:0] StIdle  = 2'd0;
    localparam logic [1:0] StDiv   = 2'd1;
    localparam logic [1:0] StBurst = 2'd2;

    logic [1:0]         r_state;
    logic signed [31:0] r_pos;
    logic               r_neg;
    logic [31:0]        r_num;
    logic [7:0]         r_rem;
    logic [4:0]         r_cnt;
    logic [BurstW-1:0]  r_burst;

    logic [32:0]  diff;
    logic [32:0]  mag;
    logic [8:0]   trial;
    logic         ge;
    logic [8:0]   trial_sub;
    logic [7:0]   n_rem;
    logic [31:0]  n_num;
    logic [3:0]   chunk;
    logic         last;
    logic [11:0]  step_pulses;
    logic [31:0]  n_pos;
    logic         accept;

    assign accept = i_valid && (r_state == StIdle);
    assign o_stall = (r_state != StIdle);

    // exact 33-bit movement and its magnitude
    assign diff = {i_encoder_position[31], i_encoder_position} - {r_pos[31], r_pos};
    assign mag  = diff[32] ? (33'd0 - diff) : diff;

    // one restoring division bit per cycle
    assign trial     = {r_rem, r_num[31]};
    assign ge        = (trial >= {1'b0, i_cfg.pps});
    assign trial_sub = trial - {1'b0, i_cfg.pps};
    assign n_rem     = ge ? trial_sub[7:0] : trial[7:0];
    assign n_num     = {r_num[30:0], ge};

    // burst: one chunk of at most 15 steps per message
    assign chunk       = (r_num > 32'(StepClamp)) ? StepClamp : r_num[3:0];
    assign last        = (r_num <= 32'(StepClamp)) || (r_burst == BurstW'(MaxBurst - 1));
    assign step_pulses = chunk * i_cfg.pps;
    assign n_pos       = r_neg ? (r_pos - 32'(step_pulses)) : (r_pos + 32'(step_pulses));

    assign o_push    = (r_state == StBurst) && (r_num != 32'd0) && !i_full;
    assign o_cmd.neg  = r_neg;
    assign o_cmd.mag  = chunk;
    assign o_cmd.last = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_pos   <= '0;
        end else begin
            case (r_state)
                StIdle: begin
                    if (accept && (i_cfg.pps != 8'd0)) begin
                        r_neg   <= diff[32];
                        r_num   <= mag[31:0];
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_burst <= '0;
                        r_state <= StDiv;
                    end
                end
                StDiv: begin
                    r_rem <= n_rem;
                    r_num <= n_num;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= StBurst;
                    end
                end
                StBurst: begin
                    if (r_num == 32'd0) begin
                        r_state <= StIdle;
                    end else if (!i_full) begin
                        r_num   <= r_num - 32'(chunk);
                        r_pos   <= n_pos;
                        r_burst <= r_burst + BurstW'(1);
                        if (last) begin
                            r_state <= StIdle;
                        end
                    end
                end
                default: begin
                    r_state <= StIdle;
                end
            endcase
        end
    end

endmodule

@@ sv/ertcc_queue.sv @@
module ertcc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ertcc_pkg::t_cmd  i_data,
    output logic             o_full,
    input  logic             i_pop,
    output ertcc_pkg::t_cmd  o_data,
    output logic             o_empty
);
    import ertcc_pkg::*;

    t_cmd           r_mem [QDepth];
    logic [QAw-1:0] r_wr;
    logic [QAw-1:0] r_rd;
    logic [QAw:0]   r_count;

    assign o_full  = (r_count == (QAw+1)'(QDepth));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAw'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAw'(1);
            end
            r_count <= r_count + (QAw+1)'(i_push) - (QAw+1)'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAw+1)'(QDepth))
        else $error("queue count beyond depth");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + (QAw+1)'(1)))
        else $error("queue count lost a push");
`endif

endmodule

@@ sv/ertcc_back.sv @@
module ertcc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ertcc_pkg::t_cfg  i_cfg,
    input  ertcc_pkg::t_cmd  i_cmd,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_out_channel,
    output logic [7:0]       o_out_controller,
    output logic [6:0]       o_cc_value,
    output logic             o_last_of_burst
);
    import ertcc_pkg::*;

    function automatic logic [6:0] encode_cc(input logic [7:0] b, input logic [1:0] mode);
        logic [7:0] m;
        logic [6:0] res;
        m = b[7] ? (8'd0 - b) : b;
        case (mode)
            ModeTwos:    res = b[6:0];
            ModeOffset:  res = b[6:0] + 7'd64;
            ModeSignMag: res = {b[7], m[5:0]};
            default:     res = 7'd0;
        endcase
        return res;
    endfunction

    logic              r_valid;
    logic [7:0]        r_channel;
    logic [7:0]        r_controller;
    logic [6:0]        r_cc;
    logic              r_last;

    logic              load;
    logic signed [4:0] steps_s;
    logic signed [12:0] scaled;
    logic [15:0]       ch_mul;
    logic [15:0]       ctl_mul;

    assign load  = !i_empty && (!r_valid || !i_stall);
    assign o_pop = load;

    assign steps_s = i_cmd.neg ? -$signed({1'b0, i_cmd.mag}) : $signed({1'b0, i_cmd.mag});
    assign scaled  = steps_s * $signed(i_cfg.gain);
    assign ch_mul  = i_cfg.bank_channel_offset * i_cfg.bank_width;
    assign ctl_mul = i_cfg.bank_address_offset * i_cfg.bank_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_channel    <= i_cfg.base_channel + ch_mul[7:0];
            r_controller <= i_cfg.base_controller + ctl_mul[7:0];
            r_cc         <= encode_cc(scaled[7:0], i_cfg.mode);
            r_last       <= i_cmd.last;
        end
    end

    assign o_valid          = r_valid;
    assign o_out_channel    = r_channel;
    assign o_out_controller = r_controller;
    assign o_cc_value       = r_cc;
    assign o_last_of_burst  = r_last;

endmodule

@@ sv/encoder_to_relative_cc_unit.sv @@
// flow: each accepted item runs the front's 32-step divider, then its burst state, which gives
//   one message per cycle while the command queue is not full, up to 16 messages per item;
//   the front takes no new item until it is back in idle, an item with a zero divisor passes
//   with no message, and output stalls hold the front up once queue and output register fill
// reset (i_rst_n low, synchronous): registers to their defaults, reported position to 0,
//   command queue and output register emptied
module encoder_to_relative_cc_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    // input item channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_encoder_position,
    // result item channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_out_channel,
    output logic [7:0]         o_out_controller,
    output logic [6:0]         o_cc_value,
    output logic               o_last_of_burst
);
    import ertcc_pkg::*;

    // configuration registers
    t_cfg r_cfg;

    // front to queue, queue to back
    t_cmd front_cmd;
    logic front_push;
    logic q_full;
    t_cmd q_cmd;
    logic q_empty;
    logic back_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pps                 <= 8'd4;
            r_cfg.gain                <= 8'd1;
            r_cfg.mode                <= ModeTwos;
            r_cfg.base_channel        <= 8'd1;
            r_cfg.base_controller     <= 8'd0;
            r_cfg.bank_channel_offset <= 8'd0;
            r_cfg.bank_address_offset <= 8'd0;
            r_cfg.bank_width          <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegPps:         r_cfg.pps                 <= i_cfg_data;
                RegGain:        r_cfg.gain                <= i_cfg_data;
                RegMode:        r_cfg.mode                <= i_cfg_data[1:0];
                RegBaseChannel: r_cfg.base_channel        <= i_cfg_data;
                RegBaseCtl:     r_cfg.base_controller     <= i_cfg_data;
                RegBankChOff:   r_cfg.bank_channel_offset <= i_cfg_data;
                RegBankAddrOff: r_cfg.bank_address_offset <= i_cfg_data;
                RegBankWidth:   r_cfg.bank_width          <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front: takes the item, divides the movement, splits it into message commands
    ertcc_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_encoder_position (i_encoder_position),
        .o_cmd              (front_cmd),
        .o_push             (front_push),
        .i_full             (q_full)
    );

    // short command queue so a stalled output does not hold up the divider
    ertcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_data  (q_cmd),
        .o_empty (q_empty)
    );

    // back: scales, encodes and registers each message
    ertcc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_cmd            (q_cmd),
        .i_empty          (q_empty),
        .o_pop            (back_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_channel    (o_out_channel),
        .o_out_controller (o_out_controller),
        .o_cc_value       (o_cc_value),
        .o_last_of_burst  (o_last_of_burst)
    );

endmodule

@@ verif/cc_message_checker.sv @@
module cc_message_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_item_valid,
    input  logic               i_item_stall,
    input  logic signed [31:0] i_position,
    input  logic               i_msg_valid,
    input  logic               i_msg_stall,
    input  logic [7:0]         i_msg_channel,
    input  logic [7:0]         i_msg_controller,
    input  logic [6:0]         i_msg_cc,
    input  logic               i_msg_last,
    output int                 o_fail_count,
    output int                 o_due_count
);
    import ertcc_pkg::*;

    typedef struct packed {
        logic [7:0] channel;
        logic [7:0] controller;
        logic [6:0] cc;
        logic       last;
    } t_cc_msg;

    logic [7:0] cfg_pps;
    logic [7:0] cfg_gain;
    logic [1:0] cfg_mode;
    logic [7:0] cfg_base_ch;
    logic [7:0] cfg_base_ctl;
    logic [7:0] cfg_bank_ch_off;
    logic [7:0] cfg_bank_addr_off;
    logic [7:0] cfg_bank_width;

    longint  reported_pos;
    t_cc_msg msgs_due[$];
    t_cc_msg got;
    t_cc_msg want;
    int      fail_count = 0;
    int      due_count  = 0;

    assign o_fail_count = fail_count;
    assign o_due_count  = due_count;

    // queue up every message one encoder sample releases
    function automatic void predict_cc_burst(input logic signed [31:0] pos);
        longint     steps;
        int         scaled;
        int         n;
        logic [7:0] b;
        logic [7:0] mag;
        logic [7:0] b_off;
        t_cc_msg    m;
        if (cfg_pps == 8'd0) begin
            return;
        end
        m.channel    = cfg_base_ch + cfg_bank_ch_off * cfg_bank_width;
        m.controller = cfg_base_ctl + cfg_bank_addr_off * cfg_bank_width;
        m.last       = 1'b0;
        n = 0;
        while (n < MaxBurst) begin
            steps = (longint'(pos) - reported_pos) / longint'(cfg_pps);
            if (steps == 0) begin
                break;
            end
            if (steps > 15) begin
                steps = 15;
            end
            if (steps < -15) begin
                steps = -15;
            end
            scaled = int'(steps) * int'($signed(cfg_gain));
            b      = scaled[7:0];
            mag    = b[7] ? (~b + 8'd1) : b;
            b_off  = b + 8'd64;
            case (cfg_mode)
                ModeTwos:    m.cc = b[6:0];
                ModeOffset:  m.cc = b_off[6:0];
                ModeSignMag: m.cc = {b[7], mag[5:0]};
                default:     m.cc = 7'd0;
            endcase
            msgs_due.push_back(m);
            reported_pos += steps * longint'(cfg_pps);
            n++;
        end
        if (n > 0) begin
            m = msgs_due.pop_back();
            m.last = 1'b1;
            msgs_due.push_back(m);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_pps           = 8'd4;
            cfg_gain          = 8'd1;
            cfg_mode          = ModeTwos;
            cfg_base_ch       = 8'd1;
            cfg_base_ctl      = 8'd0;
            cfg_bank_ch_off   = 8'd0;
            cfg_bank_addr_off = 8'd0;
            cfg_bank_width    = 8'd1;
            reported_pos      = 0;
            msgs_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    RegPps:         cfg_pps           = i_cfg_data;
                    RegGain:        cfg_gain          = i_cfg_data;
                    RegMode:        cfg_mode          = i_cfg_data[1:0];
                    RegBaseChannel: cfg_base_ch       = i_cfg_data;
                    RegBaseCtl:     cfg_base_ctl      = i_cfg_data;
                    RegBankChOff:   cfg_bank_ch_off   = i_cfg_data;
                    RegBankAddrOff: cfg_bank_addr_off = i_cfg_data;
                    RegBankWidth:   cfg_bank_width    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_item_valid && !i_item_stall) begin
                predict_cc_burst(i_position);
            end
            if (i_msg_valid && !i_msg_stall) begin
                got = '{i_msg_channel, i_msg_controller, i_msg_cc, i_msg_last};
                if (msgs_due.size() == 0) begin
                    $error("unexpected message: out_channel %0d out_controller %0d cc_value %0d",
                           got.channel, got.controller, got.cc);
                    fail_count++;
                end else begin
                    want = msgs_due.pop_front();
                    if (got.channel !== want.channel) begin
                        $error("out_channel: expected %0d, got %0d", want.channel, got.channel);
                        fail_count++;
                    end
                    if (got.controller !== want.controller) begin
                        $error("out_controller: expected %0d, got %0d",
                               want.controller, got.controller);
                        fail_count++;
                    end
                    if (got.cc !== want.cc) begin
                        $error("cc_value: expected %0d, got %0d", want.cc, got.cc);
                        fail_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("last_of_burst: expected %0d, got %0d", want.last, got.last);
                        fail_count++;
                    end
                end
            end
        end
        due_count = msgs_due.size();
    end

endmodule

@@ verif/tb_encoder_to_relative_cc_unit.sv @@
module tb_encoder_to_relative_cc_unit;
    import ertcc_pkg::*;

    // generous bound, many times the slowest correct run
    localparam int CycleLimit   = 400000;
    // block latency plus a full burst, with margin
    localparam int SettleCycles = 80;
    // the mode with no name in the package: always encodes to zero
    localparam logic [1:0] ModeZero = 2'd3;

    logic               i_clk;
    logic               i_rst_n            = 1'b0;
    logic               i_cfg_we           = 1'b0;
    logic [2:0]         i_cfg_index        = RegPps;
    logic [7:0]         i_cfg_data         = 8'd0;
    logic               i_valid            = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_encoder_position = '0;
    logic               o_valid;
    logic               i_stall            = 1'b0;
    logic [7:0]         o_out_channel;
    logic [7:0]         o_out_controller;
    logic [6:0]         o_cc_value;
    logic               o_last_of_burst;

    int     fail_count;
    int     due_count;
    int     cycle_count = 0;
    int     tx_idle_pct = 0;
    int     rx_idle_pct = 0;
    // last encoder position handed to the block
    longint cur_pos     = 0;

    encoder_to_relative_cc_unit u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_encoder_position (i_encoder_position),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_out_channel      (o_out_channel),
        .o_out_controller   (o_out_controller),
        .o_cc_value         (o_cc_value),
        .o_last_of_burst    (o_last_of_burst)
    );

    // predicts and checks every message, reports failures and what is still due
    cc_message_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_item_valid     (i_valid),
        .i_item_stall     (o_stall),
        .i_position       (i_encoder_position),
        .i_msg_valid      (o_valid),
        .i_msg_stall      (i_stall),
        .i_msg_channel    (o_out_channel),
        .i_msg_controller (o_out_controller),
        .i_msg_cc         (o_cc_value),
        .i_msg_last       (o_last_of_burst),
        .o_fail_count     (fail_count),
        .o_due_count      (due_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("encoder_to_relative_cc_unit: mismatch");
            $finish;
        end
    end

    // one item: random gap with valid low, then hold until accepted
    task automatic send_position(input logic signed [31:0] pos);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_encoder_position <= pos;
        do @(posedge i_clk); while (o_stall);
        cur_pos = pos;
    endtask

    // move relative to the last position, pinned to the 32-bit range
    task automatic send_move(input longint delta);
        longint target;
        target = cur_pos + delta;
        if (target > 64'sd2147483647) begin
            target = 64'sd2147483647;
        end
        if (target < -64'sd2147483648) begin
            target = -64'sd2147483648;
        end
        send_position(target[31:0]);
    endtask

    // write enable is left high so back-to-back writes need one assignment per edge
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] pps, input logic [7:0] gain,
                              input logic [1:0] mode, input logic [7:0] ch,
                              input logic [7:0] ctl, input logic [7:0] ch_off,
                              input logic [7:0] addr_off, input logic [7:0] width);
        write_reg(RegPps, pps);
        write_reg(RegGain, gain);
        // upper bits of the mode write are don't-care, so scramble them
        write_reg(RegMode, {6'($urandom_range(0, 63)), mode});
        write_reg(RegBaseChannel, ch);
        write_reg(RegBaseCtl, ctl);
        write_reg(RegBankChOff, ch_off);
        write_reg(RegBankAddrOff, addr_off);
        write_reg(RegBankWidth, width);
        i_cfg_we <= 1'b0;
    endtask

    // drain every expected message, then let a zero-result item finish too
    task automatic settle();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (due_count != 0) begin
            @(negedge i_clk);
        end
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    initial begin
        int rnd_pps;
        int pick;
        int span;
        tx_idle_pct = 29;
        rx_idle_pct = 82;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: below one step, one step each way, far jumps with carry-over
        send_position(3);
        send_position(4);
        send_position(-1);
        send_position(32'sh7fffffff);
        send_position(32'sh80000000);
        send_position(32'sh80000000);
        settle();

        // all-ones divisor and routing, gain 127 so overflow wraps the scaled byte
        set_config(8'd255, 8'd127, ModeTwos, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        send_position(32'sh7fffffff);
        send_position(0);
        send_move(255);
        settle();

        // unit divisor, gain of minus 127, sign magnitude, all-zero routing
        set_config(8'd1, 8'h81, ModeSignMag, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_position(100);
        send_move(-7);
        send_move(7);
        settle();

        // gain of minus one in binary offset, bank offsets in use
        set_config(8'd2, 8'hff, ModeOffset, 8'd7, 8'd9, 8'd3, 8'd3, 8'd5);
        send_move(30);
        send_move(-31);
        send_move(1);
        settle();

        // mode that always encodes zero
        set_config(8'd3, 8'd8, ModeZero, 8'd1, 8'd0, 8'd0, 8'd0, 8'd1);
        send_move(45);
        send_move(-500);
        settle();

        // zero divisor: items pass with no messages and the position holds
        set_config(8'd0, 8'd1, ModeTwos, 8'd1, 8'd0, 8'd0, 8'd0, 8'd1);
        send_position(12345);
        send_position(-7);
        settle();

        // zero gain still sends messages, each carrying a zero movement
        set_config(8'd1, 8'd0, ModeOffset, 8'd200, 8'd100, 8'd2, 8'd3, 8'd128);
        send_move(5);

        // random part: three idling schemes, two random settings each
        for (int phase = 0; phase < 6; phase++) begin
            settle();
            case (phase / 2)
                0: begin
                    tx_idle_pct = 29;
                    rx_idle_pct = 82;
                end
                1: begin
                    tx_idle_pct = 82;
                    rx_idle_pct = 29;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            // mostly small divisors so the position can actually catch up
            rnd_pps = $urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(1, 255);
            set_config(8'(rnd_pps), 8'($urandom), 2'($urandom_range(0, 3)), 8'($urandom),
                       8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            for (int k = 0; k < 17; k++) begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    // plausible turn of the knob, up to 21 steps
                    span = rnd_pps * $urandom_range(0, 20) + $urandom_range(0, rnd_pps);
                    if ($urandom_range(0, 1)) begin
                        send_move(longint'($urandom_range(0, span)));
                    end else begin
                        send_move(-longint'($urandom_range(0, span)));
                    end
                end else if (pick < 90) begin
                    // noise: arbitrary 32-bit count
                    send_position($urandom);
                end else if (pick < 95) begin
                    send_position($urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000);
                end else begin
                    send_move(0);
                end
            end
        end

        settle();
        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("encoder_to_relative_cc_unit: match");
        end else begin
            $display("encoder_to_relative_cc_unit: mismatch");
        end
        $finish;
    end

endmodule

@@ encoder_to_relative_cc_unit.f @@
sv/ertcc_pkg.sv
sv/ertcc_front.sv
sv/ertcc_queue.sv
sv/ertcc_back.sv
sv/encoder_to_relative_cc_unit.sv
verif/cc_message_checker.sv
verif/tb_encoder_to_relative_cc_unit.sv
